// ----- rtl/rhc_pkg.sv -----
// shared constants, widths and controller/datapath interface types
// of the rgb to hsv converter; depends on nothing
package rhc_pkg;

  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned HUE_W     = 15;
  localparam int unsigned SAT_W     = 13;
  localparam int unsigned COLOR_W   = 3 * CH_W;

  // quotient of a ratio that never exceeds one: integer bit plus fraction bits
  localparam int unsigned QUO_W  = FRAC_BITS + 1;
  localparam int unsigned CNT_W  = $clog2(QUO_W + 1);
  localparam int unsigned CALC_W = (FRAC_BITS + 4 > 16) ? FRAC_BITS + 4 : 16;

  localparam logic [CNT_W-1:0]  DIV_STEPS = CNT_W'(QUO_W);
  localparam logic [CALC_W-1:0] ONE       = CALC_W'(1) << FRAC_BITS;

  localparam int unsigned OUT_DATA_W = ((HUE_W + SAT_W + CH_W + 7) / 8) * 8;

  typedef struct packed {
    logic capture;
    logic eval;
    logic div_start;
    logic div_hue;
    logic store_sat;
    logic store_hue;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic changed;
    logic nonblack;
    logic chroma;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/rhc_divider.sv -----
// radix-2 restoring divider, one quotient bit per cycle, for ratios num/den <= 1
// gives floor(num * 2^FRAC_BITS / den) and a nonzero-remainder flag; uses rhc_pkg
module rhc_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rhc_pkg::CH_W-1:0]    num_i,
  input  logic [rhc_pkg::CH_W-1:0]    den_i,
  output logic                        done_o,
  output logic [rhc_pkg::QUO_W-1:0]   quo_o,
  output logic                        rem_nz_o
);

  logic [rhc_pkg::CH_W:0]       rem_q;
  logic [rhc_pkg::CH_W-1:0]     den_q;
  logic [rhc_pkg::QUO_W-1:0]    quo_q;
  logic [rhc_pkg::CNT_W-1:0]    cnt_q;
  logic                         run_q;
  logic                         done_q;

  logic                         ge;
  logic [rhc_pkg::CH_W:0]       diff;
  logic [rhc_pkg::CH_W-1:0]     rem_new;

  assign ge      = rem_q >= {1'b0, den_q};
  assign diff    = rem_q - {1'b0, den_q};
  // partial remainder stays below den after the subtract
  assign rem_new = ge ? diff[rhc_pkg::CH_W-1:0] : rem_q[rhc_pkg::CH_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= rhc_pkg::DIV_STEPS;
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == rhc_pkg::CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i};
      den_q <= den_i;
      quo_q <= '0;
    end else if (run_q) begin
      rem_q <= {rem_new, 1'b0};
      quo_q <= {quo_q[rhc_pkg::QUO_W-2:0], ge};
    end
  end

  assign done_o   = done_q;
  assign quo_o    = quo_q;
  assign rem_nz_o = rem_q != '0;

endmodule

// ----- rtl/rhc_datapath.sv -----
// datapath: pixel registers, max/min, held hue and saturation, output register
// depends on rhc_pkg and rhc_divider
module rhc_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rhc_pkg::cmd_t                     cmd_i,
  output rhc_pkg::sts_t                     sts_o,
  input  logic [rhc_pkg::COLOR_W-1:0]       pixel_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [rhc_pkg::HUE_W-1:0]         hue_o,
  output logic [rhc_pkg::SAT_W-1:0]         sat_o,
  output logic [rhc_pkg::CH_W-1:0]          value_o,
  output logic                              changed_o
);

  logic [rhc_pkg::CH_W-1:0]    r_q, g_q, b_q;
  logic [rhc_pkg::COLOR_W-1:0] last_color_q;
  logic [rhc_pkg::HUE_W-1:0]   held_hue_q;
  logic [rhc_pkg::SAT_W-1:0]   held_sat_q;
  logic                        changed_q;
  logic                        out_valid_q;
  logic [rhc_pkg::HUE_W-1:0]   out_hue_q;
  logic [rhc_pkg::SAT_W-1:0]   out_sat_q;
  logic [rhc_pkg::CH_W-1:0]    out_value_q;
  logic                        out_changed_q;

  logic [rhc_pkg::CH_W-1:0]    max_rg, min_rg, max_w, min_w;
  logic                        red_lead, green_lead;
  logic [rhc_pkg::CH_W-1:0]    num_a, num_b, mag;
  logic                        neg;
  logic [rhc_pkg::CH_W-1:0]    div_num, div_den;
  logic                        div_done;
  logic [rhc_pkg::QUO_W-1:0]   quo;
  logic                        rem_nz;
  logic [rhc_pkg::CALC_W-1:0]  quo_ext, ceil_ext, base, hue_full, sat_full;
  logic                        out_free;

  assign max_rg = (r_q > g_q) ? r_q : g_q;
  assign min_rg = (r_q < g_q) ? r_q : g_q;
  assign max_w  = (b_q > max_rg) ? b_q : max_rg;
  assign min_w  = (b_q < min_rg) ? b_q : min_rg;

  // ties go to red, then green
  assign red_lead   = max_w == r_q;
  assign green_lead = !red_lead && (max_w == g_q);

  always_comb begin
    if (red_lead) begin
      num_a = g_q;
      num_b = b_q;
    end else if (green_lead) begin
      num_a = b_q;
      num_b = r_q;
    end else begin
      num_a = r_q;
      num_b = g_q;
    end
  end

  assign neg = num_b > num_a;
  assign mag = neg ? (num_b - num_a) : (num_a - num_b);

  assign div_num = cmd_i.div_hue ? mag : min_w;
  assign div_den = cmd_i.div_hue ? (max_w - min_w) : max_w;

  rhc_divider u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.div_start),
    .num_i    (div_num),
    .den_i    (div_den),
    .done_o   (div_done),
    .quo_o    (quo),
    .rem_nz_o (rem_nz)
  );

  assign quo_ext  = {{(rhc_pkg::CALC_W - rhc_pkg::QUO_W){1'b0}}, quo};
  // negative ratios floor toward minus infinity: subtract the rounded-up quotient
  assign ceil_ext = quo_ext + {{(rhc_pkg::CALC_W - 1){1'b0}}, rem_nz};

  always_comb begin
    if (red_lead) begin
      base = neg ? ((rhc_pkg::ONE << 2) + (rhc_pkg::ONE << 1)) : '0;
    end else if (green_lead) begin
      base = rhc_pkg::ONE << 1;
    end else begin
      base = rhc_pkg::ONE << 2;
    end
  end

  assign hue_full = neg ? (base - ceil_ext) : (base + quo_ext);
  assign sat_full = rhc_pkg::ONE - quo_ext;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      r_q <= pixel_i[rhc_pkg::CH_W-1:0];
      g_q <= pixel_i[2*rhc_pkg::CH_W-1:rhc_pkg::CH_W];
      b_q <= pixel_i[3*rhc_pkg::CH_W-1:2*rhc_pkg::CH_W];
    end
    if (cmd_i.eval) begin
      changed_q <= sts_o.changed;
    end
    if (cmd_i.emit) begin
      out_hue_q     <= held_hue_q;
      out_sat_q     <= held_sat_q;
      out_value_q   <= max_w;
      out_changed_q <= changed_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_color_q <= '0;
      held_hue_q   <= '0;
      held_sat_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.eval) begin
        last_color_q <= {r_q, g_q, b_q};
      end
      if (cmd_i.store_sat) begin
        held_sat_q <= sat_full[rhc_pkg::SAT_W-1:0];
      end
      if (cmd_i.store_hue) begin
        held_hue_q <= hue_full[rhc_pkg::HUE_W-1:0];
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.changed  = {r_q, g_q, b_q} != last_color_q;
  assign sts_o.nonblack = max_w != '0;
  assign sts_o.chroma   = max_w > min_w;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign hue_o       = out_hue_q;
  assign sat_o       = out_sat_q;
  assign value_o     = out_value_q;
  assign changed_o   = out_changed_q;

  a_hue_needs_chroma : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store_hue |-> (changed_q && sts_o.chroma && div_done))
    else $error("hue stored for an unchanged or gray pixel");

  a_emit_into_free_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("result written over one not yet taken");

  a_sat_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.store_sat) |->
      ({{(rhc_pkg::CALC_W - rhc_pkg::SAT_W){1'b0}}, held_sat_q} <= rhc_pkg::ONE))
    else $error("saturation above full scale");

  a_hue_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.store_hue) |->
      ({{(rhc_pkg::CALC_W - rhc_pkg::HUE_W){1'b0}}, held_hue_q} <
       ((rhc_pkg::ONE << 2) + (rhc_pkg::ONE << 1))))
    else $error("hue beyond six sextants");

endmodule

// ----- rtl/rhc_controller.sv -----
// controller state machine sequencing capture, compare, two divisions and output
// depends on rhc_pkg
module rhc_controller (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rhc_pkg::sts_t sts_i,
  output rhc_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SAT,
    ST_HUE,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        if (sts_i.changed && sts_i.nonblack) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_SAT;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_SAT: begin
        if (sts_i.div_done) begin
          cmd_o.store_sat = 1'b1;
          if (sts_i.chroma) begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_hue   = 1'b1;
            state_d         = ST_HUE;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_HUE: begin
        // keep the hue operand mux selected while the result is stored
        cmd_o.div_hue = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.store_hue = 1'b1;
          state_d         = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == ST_IDLE;

endmodule

// ----- rtl/rgb_to_hsv_converter_core.sv -----
// top level of the rgb to hsv converter: controller plus datapath
// depends on rhc_pkg, rhc_controller, rhc_datapath (and rhc_divider below it)
//
// usage:
//   the slave stream takes one 8-bit rgb pixel per transaction; the master
//   stream gives one hsv result per pixel, in order. hue is in sextants with
//   FRAC_BITS fraction bits, saturation has 2^FRAC_BITS as full scale, value
//   is the largest channel, tuser flags a colour that differs from the last.
//   gray pixels keep the previous hue, black ones keep hue and saturation.
// sequence:
//   a pixel equal to the previous one, or black, goes from compare straight
//   to output; gray takes only the saturation division; any other colour
//   takes the saturation and then the hue division, one after the other
//   on the shared bit-serial divider.
//   one pixel is worked on at a time.
// reset clears held hue, saturation and last colour to black, empties the
//   output register and returns the controller to idle.
// a stalled master side holds the result in the output register; the next
//   pixel is still accepted and processed, and waits to be emitted until the
//   output register is taken.
module rgb_to_hsv_converter_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // red [7:0], green [15:8], blue [23:16]
  input  logic [rhc_pkg::COLOR_W-1:0]         s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // hue_out [14:0], sat_out [27:15], value_out [35:28], zero fill [39:36]
  output logic [rhc_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  // changed [0]
  output logic [0:0]                          m_axis_tuser_o
);

  rhc_pkg::cmd_t               cmd;
  rhc_pkg::sts_t               sts;
  logic [rhc_pkg::HUE_W-1:0]   hue;
  logic [rhc_pkg::SAT_W-1:0]   sat;
  logic [rhc_pkg::CH_W-1:0]    value;
  logic                        changed;

  rhc_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rhc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .pixel_i     (s_axis_tdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .hue_o       (hue),
    .sat_o       (sat),
    .value_o     (value),
    .changed_o   (changed)
  );

  assign m_axis_tdata_o = {
    {(rhc_pkg::OUT_DATA_W - rhc_pkg::HUE_W - rhc_pkg::SAT_W - rhc_pkg::CH_W){1'b0}},
    value, sat, hue
  };
  assign m_axis_tuser_o = changed;

endmodule

// ----- sim/tb_rgb_to_hsv_converter_core.sv -----
// self-checking testbench of rgb_to_hsv_converter_core: pixels go in on the slave
// stream, each hsv result is checked against a fixed-point hsv predictor
// depends on rhc_pkg and the rtl of rgb_to_hsv_converter_core
`timescale 1ns / 100ps

module tb_rgb_to_hsv_converter_core;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS = 175;
  localparam int ONE_I = 1 << rhc_pkg::FRAC_BITS;

  typedef struct {
    logic [rhc_pkg::HUE_W-1:0] hue;
    logic [rhc_pkg::SAT_W-1:0] sat;
    logic [rhc_pkg::CH_W-1:0]  value;
    logic                      changed;
  } hsv_t;

  class hsv_tracker;
    logic [rhc_pkg::HUE_W-1:0]   held_hue = '0;
    logic [rhc_pkg::SAT_W-1:0]   held_sat = '0;
    logic [rhc_pkg::COLOR_W-1:0] last_color = '0;
    hsv_t                        expected_hsv[$];
    int unsigned                 err_cnt = 0;
    int unsigned                 result_idx = 0;

    task report_mismatch(string what, int got, int want);
      $display("mismatch on result %0d, %s: got %0d expected %0d",
               result_idx, what, got, want);
      err_cnt++;
    endtask

    // floor(num * 2^FRAC_BITS / den), rounded toward minus infinity
    function int frac_floor(int num, int den);
      if (num >= 0) return (num << rhc_pkg::FRAC_BITS) / den;
      return -((((-num) << rhc_pkg::FRAC_BITS) + den - 1) / den);
    endfunction

    function void note_pixel(logic [rhc_pkg::CH_W-1:0] r, logic [rhc_pkg::CH_W-1:0] g,
                             logic [rhc_pkg::CH_W-1:0] b);
      int   ri, gi, bi, mx, mn, hue_i;
      hsv_t e;
      ri = r;
      gi = g;
      bi = b;
      mx = (ri > gi) ? ri : gi;
      mn = (ri < gi) ? ri : gi;
      if (bi > mx) mx = bi;
      if (bi < mn) mn = bi;
      e.changed = ({r, g, b} != last_color);
      if (e.changed) begin
        last_color = {r, g, b};
        // black holds both, gray holds the hue
        if (mx > 0) begin
          held_sat = rhc_pkg::SAT_W'(ONE_I - frac_floor(mn, mx));
          if (mx > mn) begin
            if (mx == ri) begin
              hue_i = frac_floor(gi - bi, mx - mn);
              if (hue_i < 0) hue_i += 6 * ONE_I;
            end else if (mx == gi) begin
              hue_i = 2 * ONE_I + frac_floor(bi - ri, mx - mn);
            end else begin
              hue_i = 4 * ONE_I + frac_floor(ri - gi, mx - mn);
            end
            held_hue = rhc_pkg::HUE_W'(hue_i);
          end
        end
      end
      e.hue   = held_hue;
      e.sat   = held_sat;
      e.value = rhc_pkg::CH_W'(mx);
      expected_hsv.push_back(e);
    endfunction

    task check_result(logic [rhc_pkg::OUT_DATA_W-1:0] data, logic user);
      hsv_t e;
      if (expected_hsv.size() == 0) begin
        report_mismatch("result with no pixel pending",
                        int'(data[rhc_pkg::HUE_W-1:0]), 0);
        result_idx++;
        return;
      end
      e = expected_hsv.pop_front();
      if (data[rhc_pkg::HUE_W-1:0] != e.hue)
        report_mismatch("hue_out", data[rhc_pkg::HUE_W-1:0], e.hue);
      if (data[rhc_pkg::HUE_W +: rhc_pkg::SAT_W] != e.sat)
        report_mismatch("sat_out", data[rhc_pkg::HUE_W +: rhc_pkg::SAT_W], e.sat);
      if (data[rhc_pkg::HUE_W+rhc_pkg::SAT_W +: rhc_pkg::CH_W] != e.value)
        report_mismatch("value_out", data[rhc_pkg::HUE_W+rhc_pkg::SAT_W +: rhc_pkg::CH_W],
                        e.value);
      if (user !== e.changed)
        report_mismatch("changed", user, e.changed);
      result_idx++;
    endtask

    function int unsigned pending();
      return expected_hsv.size();
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           s_axis_tvalid_i;
  logic                           s_axis_tready_o;
  logic [rhc_pkg::COLOR_W-1:0]    s_axis_tdata_i;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i;
  logic [rhc_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [0:0]                     m_axis_tuser_o;

  hsv_tracker  hsv_sb;
  bit          tx_quiet;
  bit          rx_quiet;
  bit          hold_req;
  logic [23:0] prev_px;
  int unsigned cycle_cnt;

  rgb_to_hsv_converter_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned gap_draw(bit quiet);
    if (quiet || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int unsigned gap;
    gap = gap_draw(tx_quiet);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {b, g, r};
    do @(posedge clk_i); while (!s_axis_tready_o);
    hsv_sb.note_pixel(r, g, b);
    prev_px = {r, g, b};
  endtask

  task automatic send_random_pixel();
    int unsigned kind;
    logic [7:0]  v;
    kind = $urandom_range(0, 99);
    v = 8'($urandom_range(0, 255));
    if (kind < 12) begin
      send_pixel(prev_px[23:16], prev_px[15:8], prev_px[7:0]);
    end else if (kind < 22) begin
      send_pixel(v, v, v);
    end else if (kind < 27) begin
      send_pixel(8'd0, 8'd0, 8'd0);
    end else if (kind < 35) begin
      // channels pinned to the rails or to one shared value, with ties among them
      send_pixel($urandom_range(0, 1) ? 8'hff : 8'h00, $urandom_range(0, 1) ? 8'hff : v,
                 $urandom_range(0, 1) ? 8'h00 : v);
    end else begin
      send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
    end
  endtask

  // result side: per result a random stall, plus one long hold-off on request
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      gap = gap_draw(rx_quiet);
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      hsv_sb.check_result(m_axis_tdata_o, m_axis_tuser_o[0]);
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("rgb_to_hsv_converter_core test failed");
    $finish;
  end

  initial begin
    hsv_sb          = new;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    tx_quiet        = 1'b0;
    rx_quiet        = 1'b0;
    hold_req        = 1'b0;
    prev_px         = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // black right after reset matches the reset colour
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    // red leads with blue above green: hue wraps below zero
    send_pixel(8'd255, 8'd0, 8'd10);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd200, 8'd50, 8'd50);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd0);
    send_pixel(8'd1, 8'd1, 8'd0);
    send_pixel(8'd254, 8'd255, 8'd255);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd170, 8'd85, 8'd255);

    // phases: no idling, idling on both sides, long result hold-off, sender idling
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    repeat (PHASE_ITEMS) send_random_pixel();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    repeat (PHASE_ITEMS) send_random_pixel();
    tx_quiet = 1'b1;
    hold_req = 1'b1;
    repeat (PHASE_ITEMS) send_random_pixel();
    tx_quiet = 1'b0;
    rx_quiet = 1'b1;
    repeat (PHASE_ITEMS) send_random_pixel();
    s_axis_tvalid_i <= 1'b0;

    while (hsv_sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (hsv_sb.pending() != 0)
      hsv_sb.report_mismatch("results still pending", 0, int'(hsv_sb.pending()));
    if (hsv_sb.err_cnt == 0)
      $display("rgb_to_hsv_converter_core test passed");
    else
      $display("rgb_to_hsv_converter_core test failed");
    $finish;
  end

endmodule
